// ----- rtl/bounded_shift_array_core_assert.svh -----
// assertion macros for the bounded shift array checker
`ifndef BOUNDED_SHIFT_ARRAY_CORE_ASSERT_SVH
`define BOUNDED_SHIFT_ARRAY_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BSAC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_shift_array_core check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BSAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_shift_array_core check failed");

`endif

// ----- rtl/bsa_pkg.sv -----
// shared types and constants for the bounded shift array
`default_nettype none

package bsa_pkg;

    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 3;
    localparam int IDX_IN_W     = 7;
    localparam int COUNT_OUT_W  = 8;
    localparam int DEF_CAPACITY = 128;

    localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND = 3'd0,
        FN_INSERT = 3'd1,
        FN_DELETE = 3'd2,
        FN_READ   = 3'd3,
        FN_SEARCH = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic append;
        logic insert;
        logic remove;
        logic query_read;
        logic query_search;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/bsa_cell.sv -----
// one storage cell of the shift array with its local match logic
`default_nettype none

module bsa_cell #(
    parameter int W = 8
) (
    input  logic                        clk,
    input  bsa_pkg::cell_cmd_t          cmd,
    input  logic [W-1:0]                cell_index,
    input  logic [W-1:0]                wr_pos,
    input  logic [W-1:0]                count,
    input  logic [W-1:0]                q_pos,
    input  logic [bsa_pkg::DATA_W-1:0]  wr_value,
    input  logic [bsa_pkg::DATA_W-1:0]  q_key,
    input  logic [bsa_pkg::DATA_W-1:0]  left_data,
    input  logic [bsa_pkg::DATA_W-1:0]  right_data,
    output logic [bsa_pkg::DATA_W-1:0]  data,
    output logic                        sel
);
    import bsa_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (cmd.append && (cell_index == count))
        begin
            data_next = wr_value;
        end
        else if (cmd.insert && (cell_index == wr_pos))
        begin
            data_next = wr_value;
        end
        else if (cmd.insert && (cell_index > wr_pos))
        begin
            data_next = left_data;
        end
        else if (cmd.remove && (cell_index >= wr_pos))
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign sel  = (cmd.query_read && (cell_index == q_pos)) ||
                  (cmd.query_search && (cell_index < count) && (data_reg == q_key));

endmodule

`default_nettype wire

// ----- rtl/bsa_tree.sv -----
// registered radix-4 first-hit tree over the cell select lines
`default_nettype none

module bsa_tree #(
    parameter int LEVELS = 4
) (
    input  logic                           clk,
    input  logic [(1 << (2*LEVELS))-1:0]   sel,
    input  logic [bsa_pkg::DATA_W-1:0]     data [1 << (2*LEVELS)],
    output logic                           hit,
    output logic [2*LEVELS-1:0]            index,
    output logic [bsa_pkg::DATA_W-1:0]     value
);
    import bsa_pkg::*;

    localparam int LEAVES = 1 << (2*LEVELS);
    localparam int NODES  = LEAVES / 4;
    localparam int IW     = 2*LEVELS;

    logic              hit_q [1:LEVELS][NODES];
    logic [IW-1:0]     idx_q [1:LEVELS][NODES];
    logic [DATA_W-1:0] val_q [1:LEVELS][NODES];

    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_level
        for (genvar n = 0; n < (LEAVES >> (2*l)); n++)
        begin : g_node
            logic              c_hit [4];
            logic [IW-1:0]     c_idx [4];
            logic [DATA_W-1:0] c_val [4];
            logic              node_hit;
            logic [IW-1:0]     node_idx;
            logic [DATA_W-1:0] node_val;

            for (genvar k = 0; k < 4; k++)
            begin : g_child
                if (l == 1)
                begin : g_leaf
                    assign c_hit[k] = sel[4*n+k];
                    assign c_idx[k] = IW'(4*n+k);
                    assign c_val[k] = data[4*n+k];
                end
                else
                begin : g_inner
                    assign c_hit[k] = hit_q[l-1][4*n+k];
                    assign c_idx[k] = idx_q[l-1][4*n+k];
                    assign c_val[k] = val_q[l-1][4*n+k];
                end
            end

            // lowest child with a hit wins
            always_comb
            begin
                node_hit = 1'b0;
                node_idx = c_idx[3];
                node_val = c_val[3];
                for (int k = 3; k >= 0; k--)
                begin
                    if (c_hit[k])
                    begin
                        node_hit = 1'b1;
                        node_idx = c_idx[k];
                        node_val = c_val[k];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                hit_q[l][n] <= node_hit;
                idx_q[l][n] <= node_idx;
                val_q[l][n] <= node_val;
            end
        end
    end

    assign hit   = hit_q[LEVELS][0];
    assign index = idx_q[LEVELS][0];
    assign value = val_q[LEVELS][0];

endmodule

`default_nettype wire

// ----- rtl/bounded_shift_array_core.sv -----
// bounded shift array: row of cells with a registered first-hit tree
// one request at a time; LEVELS = ceil(log4(CAPACITY)), 4 at CAPACITY 128
// done pulses when the phase counter, loaded on accept, has run down to zero; its load is set by the tree depth
// next request is taken only once busy has dropped again
// reset clears the fill count and control; entry contents stay as they are
`default_nettype none

module bounded_shift_array_core #(
    parameter int CAPACITY = bsa_pkg::DEF_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [bsa_pkg::FUNC_W-1:0]           func,
    input  logic [bsa_pkg::IDX_IN_W-1:0]         target_index,
    input  logic signed [bsa_pkg::DATA_W-1:0]    data_value,
    output logic                                 busy,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic signed [bsa_pkg::DATA_W-1:0]    read_value,
    output logic                                 found,
    output logic [bsa_pkg::IDX_IN_W-1:0]         found_index,
    output logic [bsa_pkg::COUNT_OUT_W-1:0]      count_now,
    output logic                                 is_empty,
    output logic                                 is_full
);
    import bsa_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int W      = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
    localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
    localparam int LEAVES = 1 << (2*LEVELS);
    localparam int IW     = 2*LEVELS;
    localparam int PH_W   = $clog2(LEVELS + 1);
    localparam int FI_W   = (IW > IDX_IN_W) ? IW : IDX_IN_W;
    localparam int CO_W   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    logic               busy_reg;
    logic               done_reg;
    logic [PH_W-1:0]    phase_reg;
    logic [CNT_W-1:0]   count_reg;

    func_t              req_func_reg;
    logic [W-1:0]       req_pos_reg;
    logic [DATA_W-1:0]  req_key_reg;
    status_t            req_status_reg;

    status_t            status_reg;
    logic [DATA_W-1:0]  read_value_reg;
    logic               found_reg;
    logic [IDX_IN_W-1:0] found_index_reg;
    logic [COUNT_OUT_W-1:0] count_now_reg;
    logic               is_empty_reg;
    logic               is_full_reg;

    logic               accept;
    logic               finish;
    logic [W-1:0]       pos_w;
    logic [W-1:0]       count_w;
    logic               arr_full;
    logic               arr_empty;
    status_t            status_c;
    logic [CNT_W-1:0]   count_c;
    logic               wr_append;
    logic               wr_insert;
    logic               wr_remove;
    cell_cmd_t          cmd;

    logic [LEAVES-1:0]  sel_vec;
    logic [DATA_W-1:0]  leaf_data [LEAVES];
    logic [DATA_W-1:0]  cell_data [CAPACITY];
    logic               root_hit;
    logic [IW-1:0]      root_idx;
    logic [DATA_W-1:0]  root_val;
    logic [FI_W-1:0]    root_idx_ext;
    logic [CO_W-1:0]    count_ext;
    logic               search_hit;

    assign accept    = start && !busy_reg;
    assign finish    = busy_reg && (phase_reg == '0);
    assign pos_w     = W'(target_index);
    assign count_w   = W'(count_reg);
    assign arr_full  = (count_reg == CNT_W'(CAPACITY));
    assign arr_empty = (count_reg == '0);

    always_comb
    begin
        status_c  = ST_DONE;
        count_c   = count_reg;
        wr_append = 1'b0;
        wr_insert = 1'b0;
        wr_remove = 1'b0;
        unique case (func_t'(func))
            FN_APPEND:
            begin
                if (arr_full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    wr_append = 1'b1;
                    count_c   = count_reg + CNT_W'(1);
                end
            end
            FN_INSERT:
            begin
                if (arr_full)
                begin
                    status_c = ST_FULL;
                end
                else if (pos_w > count_w)
                begin
                    status_c = ST_BADIDX;
                end
                else
                begin
                    wr_insert = 1'b1;
                    count_c   = count_reg + CNT_W'(1);
                end
            end
            FN_DELETE:
            begin
                if (arr_empty)
                begin
                    status_c = ST_EMPTY;
                end
                else if (pos_w >= count_w)
                begin
                    status_c = ST_BADIDX;
                end
                else
                begin
                    wr_remove = 1'b1;
                    count_c   = count_reg - CNT_W'(1);
                end
            end
            FN_READ:
            begin
                if (arr_empty)
                begin
                    status_c = ST_EMPTY;
                end
                else if (pos_w >= count_w)
                begin
                    status_c = ST_BADIDX;
                end
            end
            FN_SEARCH:
            begin
                status_c = ST_DONE;
            end
            default:
            begin
                status_c = ST_BADIDX;
            end
        endcase
    end

    always_comb
    begin
        cmd.append       = accept && wr_append;
        cmd.insert       = accept && wr_insert;
        cmd.remove       = accept && wr_remove;
        cmd.query_read   = busy_reg && (req_func_reg == FN_READ);
        cmd.query_search = busy_reg && (req_func_reg == FN_SEARCH);
    end

    for (genvar i = 0; i < LEAVES; i++)
    begin : g_cell
        if (i < CAPACITY)
        begin : g_live
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;

            if (i == 0)
            begin : g_first
                assign left_d = cell_data[i];
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[i];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[i+1];
            end

            bsa_cell #(
                .W (W)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .cell_index (W'(i)),
                .wr_pos     (pos_w),
                .count      (count_w),
                .q_pos      (req_pos_reg),
                .wr_value   (data_value),
                .q_key      (req_key_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[i]),
                .sel        (sel_vec[i])
            );

            assign leaf_data[i] = cell_data[i];
        end
        else
        begin : g_pad
            assign sel_vec[i]   = 1'b0;
            assign leaf_data[i] = '0;
        end
    end

    bsa_tree #(
        .LEVELS (LEVELS)
    ) u_tree (
        .clk   (clk),
        .sel   (sel_vec),
        .data  (leaf_data),
        .hit   (root_hit),
        .index (root_idx),
        .value (root_val)
    );

    assign root_idx_ext = FI_W'(root_idx);
    assign count_ext    = CO_W'(count_reg);
    assign search_hit   = (req_func_reg == FN_SEARCH) && root_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (accept)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_W'(LEVELS);
                count_reg <= count_c;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg - PH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_func_reg   <= func_t'(func);
            req_pos_reg    <= pos_w;
            req_key_reg    <= data_value;
            req_status_reg <= status_c;
        end
        if (finish)
        begin
            status_reg <= req_status_reg;
            if (req_func_reg == FN_READ)
            begin
                read_value_reg <= (req_status_reg == ST_DONE) ? root_val : NEG_ONE;
            end
            else
            begin
                read_value_reg <= '0;
            end
            found_reg       <= search_hit;
            found_index_reg <= search_hit ? root_idx_ext[IDX_IN_W-1:0] : '0;
            count_now_reg   <= count_ext[COUNT_OUT_W-1:0];
            is_empty_reg    <= arr_empty;
            is_full_reg     <= arr_full;
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign count_now   = count_now_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;

endmodule

`default_nettype wire

// ----- rtl/bsa_checker.sv -----
// port-level checks for the bounded shift array, bound to the top level
`default_nettype none

`include "bounded_shift_array_core_assert.svh"

module bsa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [1:0] status,
    input wire logic       found,
    input wire logic [7:0] count_now,
    input wire logic       is_empty
);
    import bsa_pkg::*;

    `BSAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `BSAC_ASSERT_NOW(a_done_idle, done, !busy)
    `BSAC_ASSERT_NEXT(a_done_single, done, !done)
    `BSAC_ASSERT_NOW(a_empty_count, done && is_empty, count_now == 8'd0)
    `BSAC_ASSERT_NOW(a_found_ok, done && found, status == ST_DONE)

endmodule

bind bounded_shift_array_core bsa_checker u_bsa_checker (.*);

`default_nettype wire
